@@ src/vital_sign_outlier_moving_average_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef VITAL_SIGN_OUTLIER_MOVING_AVERAGE_MACROS_SVH
`define VITAL_SIGN_OUTLIER_MOVING_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every edge outside reset
`define VSOMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cons must hold in the cycle after ante
`define VSOMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VSOMA_ASSERT(lbl, clk, rst, prop, msg)
`define VSOMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ src/vsoma_pkg.sv @@
package vsoma_pkg;

  localparam int SAMPLE_W = 12;
  localparam int RATE_W   = 8;
  localparam int OXY_W    = 11;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 11;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_RATE_LOW  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_RATE_HIGH = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_OXY_LOW   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MARGIN    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MISS      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_PERIOD    = 3'd5;

  // reset values
  localparam logic [RATE_W-1:0] RST_RATE_LOW  = 8'd40;
  localparam logic [RATE_W-1:0] RST_RATE_HIGH = 8'd190;
  localparam logic [OXY_W-1:0]  RST_OXY_LOW   = 11'd59;
  localparam logic [7:0]        RST_MARGIN    = 8'd10;
  localparam logic [2:0]        RST_MISS      = 3'd4;
  localparam logic [2:0]        RST_PERIOD    = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the sample and its verdict
    logic chk_rd;  // read one of the newest four entries for the outlier test
    logic upd;     // apply the verdict, write history
    logic sum_rd;  // read one entry of the averaging window
    logic fin;     // commit the average
    logic out;     // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_chk;  // outlier test applies to the latched sample
    logic sum_need;  // window sum required
    logic sum_more;  // window extends past the current index
  } stat_t;

endpackage

@@ src/vsoma_chan.sv @@
`include "vital_sign_outlier_moving_average_macros.svh"

module vsoma_chan import vsoma_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int W = 8,
  parameter bit IS_RATE = 1'b1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic [$clog2(DEPTH)-1:0]   idx,
  input  logic                       ok_in,
  input  logic [W-1:0]               val_in,
  input  logic [7:0]                 margin,
  input  logic [2:0]                 miss_limit,
  input  logic [2:0]                 check_period,
  output stat_t                      stat,
  output logic [W-1:0]               avg
);

  localparam int AW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int SW   = $clog2(FW);
  localparam int PW   = $clog2(2 * DEPTH);
  localparam int ACCW = W + FW;

  logic [W-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rd_addr;
  logic [PW-1:0]   pos;
  logic [W-1:0]    rd_data;
  logic            rd_vld;
  logic [W-1:0]    hval;

  logic            ok_q;
  logic [W-1:0]    val_q;
  logic            near_q;
  logic [2:0]      run;
  logic [2:0]      misses;
  logic [FW-1:0]   fill;
  logic [FW-1:0]   fill_next;
  logic [SW-1:0]   sh;
  logic [SW-1:0]   sh_next;
  logic [FW-1:0]   win;
  logic            sum_need;
  logic [ACCW-1:0] acc;
  logic            rd_chk_q;
  logic            rd_sum_q;
  logic            need_chk;
  logic            keep;
  logic            near_hit;
  logic            in_win;

  // newest entry sits just behind the write pointer
  always_comb begin
    pos = PW'(wp) + PW'(DEPTH - 1) - PW'(idx);
    if (pos >= PW'(DEPTH)) begin
      pos = pos - PW'(DEPTH);
    end
    rd_addr = pos[AW-1:0];
  end

  assign hval     = rd_vld ? rd_data : '0;
  assign need_chk = ok_q && (run == check_period);
  assign keep     = ok_q && !(need_chk && !near_q);
  assign win      = FW'(1) << sh;
  assign in_win   = FW'(idx) < win;

  assign stat.need_chk = need_chk;
  assign stat.sum_need = sum_need;
  assign stat.sum_more = sum_need && ((FW'(idx) + FW'(1)) < win);

  generate
    if (IS_RATE) begin : g_rate
      assign near_hit = {1'b0, val_q} < ({1'b0, hval} + (W+1)'(margin));
    end else begin : g_oxy
      assign near_hit = ({1'b0, val_q} + (W+1)'(margin)) > {1'b0, hval};
    end
  endgenerate

  assign fill_next = (fill == FW'(DEPTH)) ? fill : fill + FW'(1);

  always_comb begin
    sh_next = '0;
    for (int i = 0; i < FW; i++) begin
      if (fill_next[i]) sh_next = SW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && keep) begin
      mem[wp] <= val_q;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= valid[rd_addr];
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_q   <= ok_in;
      val_q  <= val_in;
      near_q <= 1'b0;
      acc    <= '0;
    end else begin
      if (rd_chk_q && near_hit) near_q <= 1'b1;
      if (rd_sum_q) acc <= acc + ACCW'(hval);
    end
    if (cmd.upd && keep) begin
      sh <= sh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      wp       <= '0;
      run      <= '0;
      misses   <= '0;
      fill     <= '0;
      avg      <= '0;
      sum_need <= 1'b0;
      rd_chk_q <= 1'b0;
      rd_sum_q <= 1'b0;
    end else begin
      rd_chk_q <= cmd.chk_rd && need_chk;
      rd_sum_q <= cmd.sum_rd && sum_need && in_win;
      if (cmd.load) begin
        sum_need <= 1'b0;
      end
      if (cmd.upd) begin
        if (!ok_q) begin
          run <= '0;
          if (misses == miss_limit) begin
            avg  <= '0;
            fill <= '0;
          end else begin
            misses <= misses + 3'd1;
          end
        end else begin
          misses <= '0;
          if (need_chk && !near_q) begin
            run <= '0;
          end else begin
            if (!need_chk) run <= run + 3'd1;
            valid[wp] <= 1'b1;
            wp        <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
            fill      <= fill_next;
            if (fill_next < FW'(2)) begin
              avg <= '0;
            end else begin
              sum_need <= 1'b1;
            end
          end
        end
      end
      if (cmd.fin && sum_need) begin
        avg <= W'(acc >> sh);
      end
    end
  end

  `VSOMA_ASSERT(a_fill_cap, clk, rst, fill <= FW'(DEPTH), "fill beyond history depth")
  `VSOMA_ASSERT(a_sum_fill, clk, rst, !sum_need || fill >= FW'(2), "window sum with short fill")
  `VSOMA_ASSERT_NEXT(a_reject_run, clk, rst, cmd.upd && !ok_q, run == 3'd0 && !sum_need,
                     "rejected sample left run or sum armed")

endmodule

@@ src/vsoma_ctrl.sv @@
`include "vital_sign_outlier_moving_average_macros.svh"

module vsoma_ctrl import vsoma_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic                     out_free,
  input  stat_t                    stat_rate,
  input  stat_t                    stat_oxy,
  output cmd_t                     cmd,
  output logic [$clog2(DEPTH)-1:0] idx
);

  localparam int KW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CHKW   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_SUM    = 3'd4;
  localparam logic [2:0] S_SUMW   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam logic [KW-1:0] LAST_CHK = KW'(3);

  logic [2:0]    state, state_next;
  logic [KW-1:0] k, k_next;

  assign s_tready = (state == S_IDLE);
  assign idx      = k;

  always_comb begin
    cmd        = '0;
    state_next = state;
    k_next     = k;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
          k_next     = '0;
        end
      end
      S_CHECK: begin
        if (!(stat_rate.need_chk || stat_oxy.need_chk)) begin
          state_next = S_UPDATE;
        end else begin
          cmd.chk_rd = 1'b1;
          if (k == LAST_CHK) begin
            state_next = S_CHKW;
            k_next     = '0;
          end else begin
            k_next = k + KW'(1);
          end
        end
      end
      S_CHKW: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd    = 1'b1;
        state_next = S_SUM;
        k_next     = '0;
      end
      S_SUM: begin
        if (!(stat_rate.sum_need || stat_oxy.sum_need)) begin
          state_next = S_DONE;
        end else begin
          cmd.sum_rd = 1'b1;
          if (stat_rate.sum_more || stat_oxy.sum_more) begin
            k_next = k + KW'(1);
          end else begin
            state_next = S_SUMW;
            k_next     = '0;
          end
        end
      end
      S_SUMW: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  `VSOMA_ASSERT(a_cmd_excl, clk, rst,
                $onehot0({cmd.load, cmd.chk_rd, cmd.upd, cmd.sum_rd, cmd.fin, cmd.out}),
                "more than one datapath command")
  `VSOMA_ASSERT(a_chk_idx, clk, rst, state != S_CHECK || k <= LAST_CHK,
                "outlier test index past newest four")
  `VSOMA_ASSERT_NEXT(a_fin_out, clk, rst, cmd.fin, state == S_OUT,
                     "average committed without going to output")

endmodule

@@ src/vital_sign_outlier_moving_average.sv @@
// Outlier-rejecting moving average for heart rate and oxygen saturation. Each input
// transaction carries one sample per channel (rate in s_tdata[11:0], saturation in
// s_tdata[23:12], validity flags in s_tuser) and yields exactly one output transaction
// with both current averages. One transaction is processed at a time: the controller
// walks each channel's history memory through a single read port, four reads for the
// outlier test when it is armed and one read per entry of the averaging window, so an
// item takes longer as the window grows and when the test runs. The next input is taken
// while the previous result waits in the output register. History contents survive a
// miss timeout and are cleared by reset only, through per-entry valid bits; no clearing
// pass is needed.
module vital_sign_outlier_moving_average import vsoma_pkg::*; #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // rate_sample[11:0], oxygen_sample[23:12]
  input  logic [1:0]        s_tuser,   // rate_flag[0], oxygen_flag[1]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // rate_average[7:0], oxygen_average[18:8], zeros
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int KW = $clog2(HISTORY_DEPTH);

  logic [RATE_W-1:0] rate_low_limit;
  logic [RATE_W-1:0] rate_high_limit;
  logic [OXY_W-1:0]  oxygen_low_limit;
  logic [7:0]        outlier_margin;
  logic [2:0]        miss_limit;
  logic [2:0]        check_period;

  logic [SAMPLE_W-1:0] rate_sample;
  logic [SAMPLE_W-1:0] oxygen_sample;
  logic                rate_ok;
  logic                oxygen_ok;

  cmd_t              cmd;
  stat_t             stat_rate;
  stat_t             stat_oxy;
  logic [KW-1:0]     idx;
  logic [RATE_W-1:0] rate_avg;
  logic [OXY_W-1:0]  oxygen_avg;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_low_limit   <= RST_RATE_LOW;
      rate_high_limit  <= RST_RATE_HIGH;
      oxygen_low_limit <= RST_OXY_LOW;
      outlier_margin   <= RST_MARGIN;
      miss_limit       <= RST_MISS;
      check_period     <= RST_PERIOD;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RATE_LOW:  rate_low_limit   <= cfg_data[RATE_W-1:0];
        CFG_RATE_HIGH: rate_high_limit  <= cfg_data[RATE_W-1:0];
        CFG_OXY_LOW:   oxygen_low_limit <= cfg_data[OXY_W-1:0];
        CFG_MARGIN:    outlier_margin   <= cfg_data[7:0];
        CFG_MISS:      miss_limit       <= cfg_data[2:0];
        CFG_PERIOD:    check_period     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign rate_sample   = s_tdata[11:0];
  assign oxygen_sample = s_tdata[23:12];

  // limits are unsigned, samples two's complement
  assign rate_ok = s_tuser[0]
      && ($signed({rate_sample[SAMPLE_W-1], rate_sample}) > $signed({5'b0, rate_low_limit}))
      && ($signed({rate_sample[SAMPLE_W-1], rate_sample}) < $signed({5'b0, rate_high_limit}));
  assign oxygen_ok = s_tuser[1]
      && ($signed({oxygen_sample[SAMPLE_W-1], oxygen_sample})
          > $signed({2'b0, oxygen_low_limit}));

  vsoma_ctrl #(
    .DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .stat_rate(stat_rate),
    .stat_oxy (stat_oxy),
    .cmd      (cmd),
    .idx      (idx)
  );

  vsoma_chan #(
    .DEPTH  (HISTORY_DEPTH),
    .W      (RATE_W),
    .IS_RATE(1'b1)
  ) u_rate (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .idx         (idx),
    .ok_in       (rate_ok),
    .val_in      (rate_sample[RATE_W-1:0]),
    .margin      (outlier_margin),
    .miss_limit  (miss_limit),
    .check_period(check_period),
    .stat        (stat_rate),
    .avg         (rate_avg)
  );

  vsoma_chan #(
    .DEPTH  (HISTORY_DEPTH),
    .W      (OXY_W),
    .IS_RATE(1'b0)
  ) u_oxy (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .idx         (idx),
    .ok_in       (oxygen_ok),
    .val_in      (oxygen_sample[OXY_W-1:0]),
    .margin      (outlier_margin),
    .miss_limit  (miss_limit),
    .check_period(check_period),
    .stat        (stat_oxy),
    .avg         (oxygen_avg)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      m_tdata <= {5'b0, oxygen_avg, rate_avg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
